>>> hw/rtl/ssa_pkg.sv
package ssa_pkg;

   localparam int unsigned SLOT_W   = 10;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned RESULT_LIMIT = 16;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT        = 2'd3;

   typedef struct packed {
      logic               op;
      logic [COUNT_W-1:0] request_count;
      logic [SLOT_W-1:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   granted_slot;
      logic                granted;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic               op;
      logic [COUNT_W-1:0] want;
      logic [SLOT_W-1:0]  idx;
      logic               bad_idx;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOCATE,
      BK_READ,
      BK_LOAD,
      BK_SCAN,
      BK_REL,
      BK_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/ssa_front.sv
module ssa_front #(
   parameter int unsigned NUM_SLOTS = 1024,
   parameter int unsigned MAX_BATCH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssa_pkg::req_type req_data,
   output logic             cmd_avail,
   output ssa_pkg::cmd_type cmd_data,
   input  logic             cmd_pop
);

   localparam int unsigned LIMIT =
      (MAX_BATCH < ssa_pkg::RESULT_LIMIT) ? MAX_BATCH : ssa_pkg::RESULT_LIMIT;
   localparam logic [ssa_pkg::COUNT_W-1:0] LIMIT_V = ssa_pkg::COUNT_W'(LIMIT);

   ssa_pkg::cmd_type q_ff [2];
   ssa_pkg::cmd_type cls;
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   always_comb begin
      cls.op  = req_data.op;
      cls.idx = req_data.slot_index;
      cls.want = (req_data.request_count > LIMIT_V) ? LIMIT_V : req_data.request_count;
      cls.bad_idx = (req_data.slot_index == '0) ||
                    (32'(req_data.slot_index) >= 32'(NUM_SLOTS));
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_avail = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(cmd_pop && cmd_avail)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop && cmd_avail) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop && cmd_avail) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> hw/rtl/ssa_back.sv
module ssa_back #(
   parameter int unsigned NUM_SLOTS     = 1024,
   parameter int unsigned SECTION_SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_avail,
   input  ssa_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssa_pkg::rsp_type rsp_data
);

   localparam int unsigned SPS    = SECTION_SLOTS;
   localparam int unsigned NSEC   = (NUM_SLOTS + SPS - 1) / SPS;
   localparam int unsigned SEC_W  = (NSEC > 1) ? $clog2(NSEC) : 1;
   localparam int unsigned BP_W   = $clog2(SPS);
   localparam int unsigned BASE_W = $clog2(NUM_SLOTS + 2 * SPS);
   localparam int unsigned K_W    = $clog2(ssa_pkg::RESULT_LIMIT);
   localparam logic [BASE_W-1:0] SPS_V  = BASE_W'(SPS);
   localparam logic [BASE_W-1:0] NUM_V  = BASE_W'(NUM_SLOTS);
   localparam logic [SEC_W-1:0]  LAST_SEC = SEC_W'(NSEC - 1);

   ssa_pkg::back_state_type state_ff, state_in;
   ssa_pkg::cmd_type        cmd_ff;

   logic [SPS-1:0]    mem [NSEC];
   logic [NSEC-1:0]   row_vld_ff;
   logic [SPS-1:0]    rd_data_ff;
   logic [SPS-1:0]    word_ff, word_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [BP_W-1:0]   bp_ff, bp_in;
   logic [ssa_pkg::COUNT_W-1:0] got_ff, got_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [ssa_pkg::SLOT_W-1:0] found_ff [ssa_pkg::RESULT_LIMIT];
   logic              gr_ff, gr_in;
   logic [ssa_pkg::STATUS_W-1:0] st_ff, st_in;

   logic              wr_en;
   logic [SPS-1:0]    wr_word;
   logic              fnd_we;
   logic [K_W-1:0]    fnd_addr;
   logic [ssa_pkg::SLOT_W-1:0] fnd_val;

   logic              out_free;
   logic              rsp_valid_ff;
   ssa_pkg::rsp_type  rsp_ff;
   logic              rsp_load;
   ssa_pkg::rsp_type  rsp_in;

   logic [SPS-1:0]    load_word;
   logic              word_full;
   logic [BP_W-1:0]   first_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // row not yet written reads as its reset content; slots past the end read used
   always_comb begin
      for (int b = 0; b < SPS; b++) begin
         if (row_vld_ff[sec_ff]) begin
            load_word[b] = rd_data_ff[b];
         end else begin
            load_word[b] = (sec_ff == '0) && (b == 0);
         end
         if (base_ff + BASE_W'(b) >= NUM_V) begin
            load_word[b] = 1'b1;
         end
      end
   end

   always_comb begin
      word_full  = &word_ff;
      first_free = '0;
      for (int b = SPS - 1; b >= 0; b--) begin
         if (!word_ff[b]) begin
            first_free = BP_W'(b);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      sec_in   = sec_ff;
      base_in  = base_ff;
      bp_in    = bp_ff;
      got_in   = got_ff;
      k_in     = k_ff;
      gr_in    = gr_ff;
      st_in    = st_ff;
      word_in  = word_ff;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      wr_word  = word_ff;
      fnd_we   = 1'b0;
      fnd_addr = '0;
      fnd_val  = '0;
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;

      case (state_ff)
         ssa_pkg::BK_IDLE: begin
            if (cmd_avail) begin
               cmd_pop = 1'b1;
               sec_in  = '0;
               base_in = '0;
               got_in  = '0;
               k_in    = '0;
               fnd_we  = 1'b1;
               fnd_val = cmd_data.idx;
               gr_in   = 1'b0;
               if (cmd_data.op == ssa_pkg::OP_RELEASE) begin
                  if (cmd_data.bad_idx) begin
                     got_in   = ssa_pkg::COUNT_W'(1);
                     st_in    = ssa_pkg::ST_INVALID;
                     state_in = ssa_pkg::BK_EMIT;
                  end else begin
                     state_in = ssa_pkg::BK_LOCATE;
                  end
               end else if (cmd_data.want == '0) begin
                  got_in   = ssa_pkg::COUNT_W'(1);
                  fnd_val  = '0;
                  st_in    = ssa_pkg::ST_OK;
                  state_in = ssa_pkg::BK_EMIT;
               end else begin
                  state_in = ssa_pkg::BK_READ;
               end
            end
         end
         ssa_pkg::BK_LOCATE: begin
            // walk section bases until the index falls inside one
            if (BASE_W'(cmd_ff.idx) < base_ff + SPS_V) begin
               bp_in    = BP_W'(BASE_W'(cmd_ff.idx) - base_ff);
               state_in = ssa_pkg::BK_READ;
            end else begin
               sec_in  = sec_ff + SEC_W'(1);
               base_in = base_ff + SPS_V;
            end
         end
         ssa_pkg::BK_READ: begin
            state_in = ssa_pkg::BK_LOAD;
         end
         ssa_pkg::BK_LOAD: begin
            word_in  = load_word;
            state_in = (cmd_ff.op == ssa_pkg::OP_RELEASE) ? ssa_pkg::BK_REL
                                                          : ssa_pkg::BK_SCAN;
         end
         ssa_pkg::BK_SCAN: begin
            if (word_full || got_ff == cmd_ff.want) begin
               wr_en = 1'b1;
               if (got_ff == cmd_ff.want || sec_ff == LAST_SEC) begin
                  state_in = ssa_pkg::BK_EMIT;
                  if (got_ff == '0) begin
                     got_in   = ssa_pkg::COUNT_W'(1);
                     fnd_we   = 1'b1;
                     fnd_val  = '0;
                     gr_in    = 1'b0;
                     st_in    = ssa_pkg::ST_SHORT;
                  end else begin
                     gr_in = 1'b1;
                     st_in = (got_ff < cmd_ff.want) ? ssa_pkg::ST_SHORT : ssa_pkg::ST_OK;
                  end
               end else begin
                  sec_in   = sec_ff + SEC_W'(1);
                  base_in  = base_ff + SPS_V;
                  state_in = ssa_pkg::BK_READ;
               end
            end else begin
               word_in[first_free] = 1'b1;
               fnd_we   = 1'b1;
               fnd_addr = K_W'(got_ff);
               fnd_val  = ssa_pkg::SLOT_W'(base_ff + BASE_W'(first_free));
               got_in   = got_ff + ssa_pkg::COUNT_W'(1);
            end
         end
         ssa_pkg::BK_REL: begin
            got_in   = ssa_pkg::COUNT_W'(1);
            state_in = ssa_pkg::BK_EMIT;
            if (word_ff[bp_ff]) begin
               wr_en          = 1'b1;
               wr_word[bp_ff] = 1'b0;
               st_in          = ssa_pkg::ST_OK;
            end else begin
               st_in = ssa_pkg::ST_ALREADY_FREE;
            end
         end
         ssa_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.granted_slot = found_ff[k_ff];
               rsp_in.granted      = gr_ff;
               rsp_in.status       = st_ff;
               rsp_in.last         = (ssa_pkg::COUNT_W'(k_ff) + 1'b1 == got_ff);
               k_in                = k_ff + K_W'(1);
               if (rsp_in.last) begin
                  state_in = ssa_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = ssa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssa_pkg::BK_IDLE;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            row_vld_ff[sec_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      sec_ff  <= sec_in;
      base_ff <= base_in;
      bp_ff   <= bp_in;
      got_ff  <= got_in;
      k_ff    <= k_in;
      gr_ff   <= gr_in;
      st_ff   <= st_in;
      word_ff <= word_in;
      if (fnd_we) begin
         found_ff[fnd_addr] <= fnd_val;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[sec_ff];
      if (wr_en) begin
         mem[sec_ff] <= wr_word;
      end
   end

   a_got_le_want: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssa_pkg::BK_SCAN) |-> (got_ff <= cmd_ff.want))
      else $error("more slots taken than requested");

   a_no_reserved_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.granted) |-> (rsp_ff.granted_slot != '0))
      else $error("reserved slot granted");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ssa_pkg::BK_SCAN || state_ff == ssa_pkg::BK_REL))
      else $error("bitmap written outside scan or release");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff != ssa_pkg::BK_IDLE))
      else $error("command popped without being taken");

endmodule

>>> hw/rtl/sectioned_slot_allocator.sv
// Sectioned slot allocator: used/free bitmap over NUM_SLOTS slots in sections.
// Request channel (req_valid/req_stall/req_data): op 0 allocates up to
// request_count slots (clamped to MAX_BATCH and 16), op 1 releases slot_index.
// Result channel (rsp_valid/rsp_stall/rsp_data): allocate returns one beat per
// granted slot in ascending order, last on the final beat, status short on all
// beats when fewer were found, or one empty beat. Release returns one beat.
// A two-entry request queue decouples intake from the execution engine, which
// reads one bitmap row per section (read, load, then one find-first per cycle).
// A release walks the section bases to its section, then reads, loads, checks
// and clears the bit and emits; an allocate reads, loads and scans each section
// it visits, then emits. Further beats follow one per cycle while the result
// channel is not stalled. The engine runs one command at a time. Reset empties
// the queue and marks every bitmap row as holding its reset content (slot 0
// used, rest free), so no clearing pass is needed. A stalled result holds its
// beat in the output register; the engine waits, and the queue keeps accepting
// until full.
module sectioned_slot_allocator #(
   parameter int unsigned NUM_SLOTS     = 1024,
   parameter int unsigned SECTION_SLOTS = 64,
   parameter int unsigned MAX_BATCH     = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssa_pkg::rsp_type rsp_data
);

   // classified command handoff
   logic             cmd_avail;
   logic             cmd_pop;
   ssa_pkg::cmd_type cmd_data;

   ssa_front #(
      .NUM_SLOTS (NUM_SLOTS),
      .MAX_BATCH (MAX_BATCH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_avail (cmd_avail),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // engine owns the bitmap and the output register
   ssa_back #(
      .NUM_SLOTS     (NUM_SLOTS),
      .SECTION_SLOTS (SECTION_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (cmd_avail),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
